// ----- rtl/dsv_pkg.sv -----
`default_nettype none

package dsv_pkg;

    // character codes
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_SLASH = 8'd47;

    // field position codes
    localparam logic [1:0] FIELD_DAY   = 2'd0;
    localparam logic [1:0] FIELD_MONTH = 2'd1;
    localparam logic [1:0] FIELD_YEAR  = 2'd2;

    // date limits
    localparam logic [6:0]  MAX_DAY        = 7'd31;
    localparam logic [6:0]  MAX_DAY_SHORT  = 7'd30;
    localparam logic [6:0]  MAX_DAY_FEB    = 7'd29;
    localparam logic [6:0]  MAX_DAY_FEB_NL = 7'd28;
    localparam logic [6:0]  MAX_MONTH      = 7'd12;
    localparam logic [6:0]  MONTH_FEB      = 7'd2;
    localparam logic [6:0]  MONTH_APR      = 7'd4;
    localparam logic [6:0]  MONTH_JUN      = 7'd6;
    localparam logic [6:0]  MONTH_SEP      = 7'd9;
    localparam logic [6:0]  MONTH_NOV      = 7'd11;
    localparam logic [13:0] MAX_YEAR_RESET = 14'd2021;

    // digit limits per field
    localparam logic [2:0] DM_DIGITS      = 3'd2;
    localparam logic [2:0] YEAR_DIGITS    = 3'd4;
    localparam logic [2:0] YEAR_DIGITS_SH = 3'd2;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic        valid_res;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } out_word_t;

endpackage

`default_nettype wire

// ----- rtl/dsv_parser.sv -----
`default_nettype none

module dsv_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire dsv_pkg::in_word_t  word,
    input  wire logic [13:0]        max_year,
    output dsv_pkg::out_word_t      res
);
    import dsv_pkg::*;

    logic [1:0]  field_reg, field_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  month_reg, month_next;
    logic [13:0] year_reg, year_next;
    logic [15:0] ybcd_reg, ybcd_next;
    logic        err_reg, err_next;

    logic        is_digit;
    logic        is_slash;
    logic [3:0]  dv;
    logic        at_limit;
    logic        leap;
    logic        ok;
    logic [1:0]  mod4_lo;
    logic [1:0]  mod4_hi;
    logic        short_month;

    // character classes
    assign is_digit = (word.ch >= CH_ZERO) && (word.ch <= CH_NINE);
    assign is_slash = (word.ch == CH_SLASH);
    assign dv       = word.ch[3:0];
    assign at_limit = (field_reg == FIELD_YEAR) ? (cnt_reg >= YEAR_DIGITS)
                                                : (cnt_reg >= DM_DIGITS);

    // next parse state for the current character
    always_comb
    begin
        field_next = field_reg;
        cnt_next   = cnt_reg;
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        ybcd_next  = ybcd_reg;
        err_next   = err_reg;
        if (is_digit)
        begin
            if (at_limit)
            begin
                err_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 3'd1;
                case (field_reg)
                    FIELD_DAY:
                    begin
                        day_next = {day_reg[3:0], 3'b000} + {day_reg[5:0], 1'b0}
                                   + {3'b000, dv};
                    end
                    FIELD_MONTH:
                    begin
                        month_next = {month_reg[3:0], 3'b000} + {month_reg[5:0], 1'b0}
                                     + {3'b000, dv};
                    end
                    default:
                    begin
                        year_next = {year_reg[10:0], 3'b000} + {year_reg[12:0], 1'b0}
                                    + {10'd0, dv};
                        ybcd_next = {ybcd_reg[11:0], dv};
                    end
                endcase
            end
        end
        else if (is_slash)
        begin
            if ((field_reg >= FIELD_YEAR) || (cnt_reg == 3'd0))
            begin
                err_next = 1'b1;
            end
            else
            begin
                field_next = field_reg + 2'd1;
                cnt_next   = 3'd0;
            end
        end
        else
        begin
            err_next = 1'b1;
        end
    end

    // gregorian leap rule on the decimal digits of the year
    assign mod4_lo = ybcd_next[1:0] + {ybcd_next[4], 1'b0};
    assign mod4_hi = ybcd_next[9:8] + {ybcd_next[12], 1'b0};
    always_comb
    begin
        if (mod4_lo != 2'd0)
        begin
            leap = 1'b0;
        end
        else if (ybcd_next[7:0] != 8'd0)
        begin
            leap = 1'b1;
        end
        else
        begin
            leap = (mod4_hi == 2'd0);
        end
    end

    // date check on the updated state
    assign short_month = (month_next == MONTH_APR) || (month_next == MONTH_JUN)
                      || (month_next == MONTH_SEP) || (month_next == MONTH_NOV);

    always_comb
    begin
        ok = !err_next && (field_next == FIELD_YEAR)
             && ((cnt_next == YEAR_DIGITS_SH) || (cnt_next == YEAR_DIGITS))
             && (day_next != 7'd0) && (day_next <= MAX_DAY)
             && (month_next != 7'd0) && (month_next <= MAX_MONTH)
             && (year_next != 14'd0) && (year_next <= max_year);
        if (short_month && (day_next > MAX_DAY_SHORT))
        begin
            ok = 1'b0;
        end
        if (month_next == MONTH_FEB)
        begin
            if (day_next > MAX_DAY_FEB)
            begin
                ok = 1'b0;
            end
            if ((day_next > MAX_DAY_FEB_NL) && !leap)
            begin
                ok = 1'b0;
            end
        end
    end

    assign res.valid_res = ok;
    assign res.day       = ok ? day_next[4:0]   : 5'd0;
    assign res.month     = ok ? month_next[3:0] : 4'd0;
    assign res.year      = ok ? year_next       : 14'd0;

    // parse state, cleared after the final character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg <= FIELD_DAY;
            cnt_reg   <= 3'd0;
            day_reg   <= 7'd0;
            month_reg <= 7'd0;
            year_reg  <= 14'd0;
            ybcd_reg  <= 16'd0;
            err_reg   <= 1'b0;
        end
        else if (step)
        begin
            if (word.last)
            begin
                field_reg <= FIELD_DAY;
                cnt_reg   <= 3'd0;
                day_reg   <= 7'd0;
                month_reg <= 7'd0;
                year_reg  <= 14'd0;
                ybcd_reg  <= 16'd0;
                err_reg   <= 1'b0;
            end
            else
            begin
                field_reg <= field_next;
                cnt_reg   <= cnt_next;
                day_reg   <= day_next;
                month_reg <= month_next;
                year_reg  <= year_next;
                ybcd_reg  <= ybcd_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/date_string_validator_top.sv -----
`default_nettype none

// channel   signals                          word
// input     in_valid, in_ready, in_data      one character and its last flag
// output    out_valid, out_ready, out_data   verdict with day, month and year
// config    cfg_we, cfg_wdata                largest accepted year
//
// one character a cycle: a character is held in the input register,
// then updates the parse state; the final one loads the result register.
// the result is offered once the final character leaves the input register.
// reset clears the parse state and sets the largest year to 2021.
// a stalled result only holds back a final character; others keep flowing.

module date_string_validator_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire dsv_pkg::in_word_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output dsv_pkg::out_word_t  out_data,
    input  wire logic           cfg_we,
    input  wire logic [13:0]    cfg_wdata
);
    import dsv_pkg::*;

    logic        in_full_reg;
    in_word_t    in_word_reg;
    logic        out_valid_reg;
    out_word_t   out_word_reg;
    logic [13:0] max_year_reg;
    logic        advance;
    out_word_t   res;

    // the held character moves on unless it needs a busy result register
    assign advance  = in_full_reg && (!in_word_reg.last || !out_valid_reg || out_ready);
    assign in_ready = !in_full_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_full_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_word_reg <= in_data;
        end
    end

    // year limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_year_reg <= MAX_YEAR_RESET;
        end
        else if (cfg_we)
        begin
            max_year_reg <= cfg_wdata;
        end
    end

    // parse state and date check
    dsv_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .word     (in_word_reg),
        .max_year (max_year_reg),
        .res      (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_word_reg.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_word_reg.last)
        begin
            out_word_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    // checks
    a_final_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_word_reg.last) |=> out_valid_reg)
        else $error("final character did not load a result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !(advance && in_word_reg.last))
        else $error("pending result overwritten");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_word_reg.valid_res) |->
        (out_word_reg.day == 5'd0 && out_word_reg.month == 4'd0
         && out_word_reg.year == 14'd0))
        else $error("invalid result carries nonzero fields");

    a_valid_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.valid_res) |->
        (out_word_reg.day != 5'd0 && out_word_reg.month != 4'd0
         && out_word_reg.month <= 4'd12 && out_word_reg.year != 14'd0
         && out_word_reg.year <= max_year_reg))
        else $error("valid result out of range");

endmodule

`default_nettype wire
